[rtl/pfx_pkg.sv]
// Shared types and constants of the packet framer.
package pfx_pkg;

	localparam int MaxRes = 5;

	typedef enum logic [1:0] {
		ST_BYTE      = 2'd0,
		ST_TOO_LONG  = 2'd1,
		ST_NOT_READY = 2'd2,
		ST_STRAY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_LINK_READY   = 2'd0,
		CFG_START_MARKER = 2'd1,
		CFG_END_MARKER   = 2'd2
	} cfg_idx_t;

	localparam logic [7:0] StartMarkerRst = 8'hAA;
	localparam logic [7:0] EndMarkerRst   = 8'h55;

	typedef struct packed {
		logic       link_ready;
		logic [7:0] start_marker;
		logic [7:0] end_marker;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] packet_type;
		logic [7:0] payload_length;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		status_t    status;
	} res_t;

	// Results of one word: entries 0 .. cnt-1 are used.
	typedef struct packed {
		res_t [MaxRes-1:0] res;
		logic [2:0]        cnt;
	} bundle_t;

endpackage

[rtl/pfx_core.sv]
// Frame state and per-word result generation.
module pfx_core #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pfx_pkg::item_t   item,
	input  pfx_pkg::cfg_t    cfg,
	input  logic             adv,
	output pfx_pkg::bundle_t bundle
);
	import pfx_pkg::*;

	localparam logic [8:0] MaxFrame = 9'(MAX_FRAME_BYTES);

	logic       frame_open_q;
	logic       discarding_q;
	logic [7:0] bytes_left_q;
	logic [7:0] running_xor_q;

	logic       frame_open_d;
	logic       discarding_d;
	logic [7:0] bytes_left_d;
	logic [7:0] running_xor_d;

	logic [7:0] bl_dec;
	logic [7:0] xor_next;
	logic       too_long;

	assign bl_dec   = bytes_left_q - 8'd1;
	assign xor_next = running_xor_q ^ item.data_byte;
	assign too_long = ({1'b0, item.payload_length} + 9'd5) > MaxFrame;

	always_comb begin
		bundle        = '0;
		frame_open_d  = frame_open_q;
		discarding_d  = discarding_q;
		bytes_left_d  = bytes_left_q;
		running_xor_d = running_xor_q;
		if (!item.kind) begin
			// a header always abandons whatever was in progress
			frame_open_d  = 1'b0;
			discarding_d  = 1'b0;
			bytes_left_d  = '0;
			running_xor_d = '0;
			if (!cfg.link_ready || too_long) begin
				bundle.res[0].status = cfg.link_ready ? ST_TOO_LONG : ST_NOT_READY;
				bundle.cnt           = 3'd1;
				if (item.payload_length != 8'd0) begin
					discarding_d = 1'b1;
					bytes_left_d = item.payload_length;
				end
			end else begin
				bundle.res[0] = '{data: cfg.start_marker, status: ST_BYTE};
				bundle.res[1] = '{data: item.packet_type, status: ST_BYTE};
				bundle.res[2] = '{data: item.payload_length, status: ST_BYTE};
				if (item.payload_length == 8'd0) begin
					bundle.res[3] = '{data: 8'd0, status: ST_BYTE};
					bundle.res[4] = '{data: cfg.end_marker, status: ST_BYTE};
					bundle.cnt    = 3'd5;
				end else begin
					bundle.cnt   = 3'd3;
					frame_open_d = 1'b1;
					bytes_left_d = item.payload_length;
				end
			end
		end else if (frame_open_q) begin
			bundle.res[0] = '{data: item.data_byte, status: ST_BYTE};
			bundle.cnt    = 3'd1;
			bytes_left_d  = bl_dec;
			running_xor_d = xor_next;
			if (bl_dec == 8'd0) begin
				bundle.res[1] = '{data: xor_next, status: ST_BYTE};
				bundle.res[2] = '{data: cfg.end_marker, status: ST_BYTE};
				bundle.cnt    = 3'd3;
				frame_open_d  = 1'b0;
				running_xor_d = '0;
			end
		end else if (discarding_q) begin
			bytes_left_d = bl_dec;
			if (bl_dec == 8'd0) begin
				discarding_d = 1'b0;
			end
		end else begin
			bundle.res[0].status = ST_STRAY;
			bundle.cnt           = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q  <= 1'b0;
			discarding_q  <= 1'b0;
			bytes_left_q  <= '0;
			running_xor_q <= '0;
		end else if (adv) begin
			frame_open_q  <= frame_open_d;
			discarding_q  <= discarding_d;
			bytes_left_q  <= bytes_left_d;
			running_xor_q <= running_xor_d;
		end
	end

`ifndef ASSERT_OFF
	a_open_xor_discard: assert property (@(posedge clk) disable iff (!arst_n)
		!(frame_open_q && discarding_q))
		else $error("frame open and discarding at once");
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_open_q || discarding_q) |-> (bytes_left_q != 8'd0))
		else $error("open frame with no bytes left");
	a_idle_xor: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> (running_xor_q == 8'd0))
		else $error("checksum not cleared outside a frame");
`endif

endmodule

[rtl/pfx_ser.sv]
// Result register: holds one word's results and sends them one per cycle while the output is not stalled.
module pfx_ser (
	input  logic             clk,
	input  logic             arst_n,
	input  pfx_pkg::bundle_t bundle,
	input  logic             load,
	input  logic             out_stall,
	output logic             out_valid,
	output pfx_pkg::res_t    res,
	output logic             last,
	output logic             can_load
);
	import pfx_pkg::*;

	res_t [MaxRes-1:0] res_q;
	logic [2:0]        cnt_q;
	logic [2:0]        idx_q;
	logic              fire;

	assign out_valid = (cnt_q != 3'd0);
	assign last      = (idx_q == cnt_q - 3'd1);
	assign res       = res_q[idx_q];
	assign fire      = out_valid && !out_stall;
	assign can_load  = !out_valid || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
			idx_q <= '0;
		end else if (fire) begin
			if (last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle.res;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd5)
		else $error("result count out of range");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < cnt_q))
		else $error("result index past count");
	a_keep_going: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !last) |=> (out_valid && idx_q == $past(idx_q) + 3'd1))
		else $error("word results cut short");
`endif

endmodule

[rtl/packet_framer_xor_checksum.sv]
// Packet framer with XOR checksum: top level.
//
// Input channel (in_valid/in_stall): one word per item; kind 0 is a header
// carrying packet_type and payload_length, kind 1 carries one data_byte.
// Output channel (out_valid/out_stall): one frame byte or status per word,
// last marks the final result of an input word.
// A header gives start marker, type and length (plus checksum and end
// marker when the payload is empty); each payload byte gives itself, the
// final one also the XOR checksum and end marker. Rejected headers give a
// single status word and their payload bytes vanish.
// A word is held in the input register, then its results in the result
// register. Throughput: one word per cycle while each word has one
// result and the output is not stalled; a word with n results holds the
// output register until all n are sent, so headers give 3 or 5 results
// and the closing payload byte 3, as the output port is single. Words
// with no result (discarded bytes) pass without using the output
// register. Configuration (cfg_we/cfg_index/cfg_wdata) is to be written
// by the user only while idle; the block does not enforce it. Reset
// clears frame state and all queued results and restores the markers
// to 0xAA and 0x55 with the link not ready. A stalled output holds its
// word and backs up into in_stall; nothing is lost.
module packet_framer_xor_checksum #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] packet_type,
	input  logic [7:0] payload_length,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       last,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import pfx_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	bundle_t bundle;
	res_t    res;
	logic    can_load;
	logic    adv;
	logic    load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_ready   <= 1'b0;
			cfg_q.start_marker <= StartMarkerRst;
			cfg_q.end_marker   <= EndMarkerRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LINK_READY:   cfg_q.link_ready   <= cfg_wdata[0];
				CFG_START_MARKER: cfg_q.start_marker <= cfg_wdata;
				CFG_END_MARKER:   cfg_q.end_marker   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register; a word leaves it once its results fit the output side
	assign adv      = valid_s1 && ((bundle.cnt == 3'd0) || can_load);
	assign load     = adv && (bundle.cnt != 3'd0);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{kind: kind, packet_type: packet_type,
				payload_length: payload_length, data_byte: data_byte};
		end
	end

	pfx_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.cfg    (cfg_q),
		.adv    (adv),
		.bundle (bundle)
	);

	pfx_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.load      (load),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res),
		.last      (last),
		.can_load  (can_load)
	);

	assign out_byte = res.data;
	assign status   = res.status;

endmodule

[tb/tb_packet_framer_xor_checksum.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the packet framer with XOR checksum.
module tb_packet_framer_xor_checksum;
	import pfx_pkg::*;

	localparam int MaxFrame = 64;
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA = 1'b1;
	localparam int FlushCycles = 10;

	typedef struct {
		logic [7:0] data;
		status_t    st;
		logic       lst;
	} out_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       kind = 1'b0;
	logic [7:0] packet_type = '0;
	logic [7:0] payload_length = '0;
	logic [7:0] data_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	// framer state mirror
	logic       link_up = 1'b0;
	logic [7:0] sof_byte = StartMarkerRst;
	logic [7:0] eof_byte = EndMarkerRst;
	logic       in_frame = 1'b0;
	logic       dropping = 1'b0;
	logic [7:0] left_cnt = '0;
	logic [7:0] csum = '0;

	out_word_t  frame_q[$];
	int         src_idle = 10;
	int         snk_idle = 77;
	int         hold_left = 0;
	int         err_cnt = 0;
	int         useful_cnt = 0;

	packet_framer_xor_checksum #(.MAX_FRAME_BYTES(MaxFrame)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .packet_type(packet_type),
		.payload_length(payload_length), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .status(status), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb_packet_framer_xor_checksum: FAIL");
		$finish;
	end

	// Works out the frame bytes / status words one input word gives.
	function automatic int frame_item(logic k, logic [7:0] ptype, logic [7:0] plen,
			logic [7:0] dbyte);
		out_word_t w[$];
		if (k == KIND_HEADER) begin
			in_frame = 1'b0;
			dropping = 1'b0;
			left_cnt = '0;
			csum = '0;
			if (!link_up || int'(plen) + 5 > MaxFrame) begin
				w.push_back('{8'h00, link_up ? ST_TOO_LONG : ST_NOT_READY, 1'b0});
				if (plen != 0) begin
					dropping = 1'b1;
					left_cnt = plen;
				end
			end else begin
				w.push_back('{sof_byte, ST_BYTE, 1'b0});
				w.push_back('{ptype, ST_BYTE, 1'b0});
				w.push_back('{plen, ST_BYTE, 1'b0});
				if (plen == 0) begin
					w.push_back('{8'h00, ST_BYTE, 1'b0});
					w.push_back('{eof_byte, ST_BYTE, 1'b0});
				end else begin
					in_frame = 1'b1;
					left_cnt = plen;
				end
			end
		end else if (in_frame) begin
			w.push_back('{dbyte, ST_BYTE, 1'b0});
			csum = csum ^ dbyte;
			left_cnt = left_cnt - 8'd1;
			if (left_cnt == 0) begin
				w.push_back('{csum, ST_BYTE, 1'b0});
				w.push_back('{eof_byte, ST_BYTE, 1'b0});
				in_frame = 1'b0;
				csum = '0;
			end
		end else if (dropping) begin
			left_cnt = left_cnt - 8'd1;
			if (left_cnt == 0) begin
				dropping = 1'b0;
			end
		end else begin
			w.push_back('{8'h00, ST_STRAY, 1'b0});
		end
		if (w.size() > 0) begin
			w[w.size() - 1].lst = 1'b1;
		end
		foreach (w[i]) frame_q.push_back(w[i]);
		return w.size();
	endfunction

	// in_valid is left high after a word is taken; the next call or a drain
	// decides its value, so it never sees two updates in one step.
	task automatic send_word(input logic k, input logic [7:0] ptype, input logic [7:0] plen,
			input logic [7:0] dbyte);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		packet_type <= ptype;
		payload_length <= plen;
		data_byte <= dbyte;
		do @(posedge clk); while (in_stall);
		if (frame_item(k, ptype, plen, dbyte) > 0) begin
			useful_cnt++;
		end
	endtask

	task automatic send_header(input logic [7:0] ptype, input logic [7:0] plen);
		send_word(KIND_HEADER, ptype, plen, 8'($urandom_range(255)));
	endtask

	task automatic send_data(input logic [7:0] dbyte);
		send_word(KIND_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)), dbyte);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		// discarded words may still be in flight
		repeat (FlushCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LINK_READY: link_up = val[0];
			CFG_START_MARKER: sof_byte = val;
			CFG_END_MARKER: eof_byte = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic link, input logic [7:0] sof, input logic [7:0] eof);
		wait_drain();
		write_reg(CFG_LINK_READY, {7'd0, link});
		write_reg(CFG_START_MARKER, sof);
		write_reg(CFG_END_MARKER, eof);
	endtask

	// out of reset the link is down
	task automatic test_link_not_ready();
		send_data(8'hFF);
		send_header(8'h12, 8'd2);
		send_data(8'h01);
		send_data(8'h02);
		send_data(8'h00);
		send_header(8'h34, 8'd0);
		send_data(8'h5A);
	endtask

	// reset markers still in place here
	task automatic test_frame_shapes();
		wait_drain();
		write_reg(CFG_LINK_READY, 8'd1);
		send_header(8'h00, 8'd0);
		send_header(8'hFF, 8'd1);
		send_data(8'hFF);
		send_header(8'h5A, 8'd3);
		send_data(8'h00);
		send_data(8'hA5);
		send_data(8'h5A);
	endtask

	task automatic test_length_limits();
		send_header(8'h3C, 8'(MaxFrame - 5));
		send_data(8'h01);
		send_data(8'h80);
		// open frame abandoned by a header one byte too long
		send_header(8'h11, 8'(MaxFrame - 4));
		send_header(8'h22, 8'hFF);
		send_data(8'hC3);
		send_data(8'h3C);
		// header while dropping bytes
		send_header(8'h33, 8'd0);
		send_header(8'h44, 8'd2);
		send_data(8'h7E);
	endtask

	task automatic test_markers();
		configure(1'b1, 8'h00, 8'hFF);
		send_header(8'hA1, 8'd1);
		send_data(8'h3C);
		configure(1'b1, 8'hFF, 8'h00);
		send_header(8'hB2, 8'd0);
	endtask

	// long receiver hold-off with a full-size frame queued behind it
	task automatic test_backpressure();
		configure(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
		src_idle = 0;
		hold_left = 300;
		send_header(8'($urandom_range(255)), 8'(MaxFrame - 5));
		repeat (MaxFrame - 5) send_data(8'($urandom_range(255)));
		wait_drain();
	endtask

	task automatic random_packet();
		int unsigned pick;
		int unsigned plen;
		int unsigned nsend;
		pick = $urandom_range(99);
		if (pick < 6) begin
			send_data(8'($urandom_range(255)));
			return;
		end
		if (pick < 9) begin
			wait_drain();
		end
		if (pick < 16) begin
			plen = $urandom_range(255, MaxFrame - 4);
		end else if (pick < 30) begin
			plen = $urandom_range(MaxFrame - 5, 11);
		end else begin
			plen = $urandom_range(10, 0);
		end
		nsend = plen;
		if (pick < 16) begin
			nsend = $urandom_range(6);
		end else if ($urandom_range(99) < 8) begin
			nsend = $urandom_range(plen);
		end
		send_header(8'($urandom_range(255)), 8'(plen));
		repeat (nsend) send_data(8'($urandom_range(255)));
	endtask

	task automatic test_random(input int target);
		int phase_end;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 10;
					snk_idle = 77;
					configure(1'b1, 8'h00, 8'hFF);
				end
				1: begin
					src_idle = 77;
					snk_idle = 10;
					configure(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
					repeat (8) random_packet();
					configure(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
				end
				default: begin
					src_idle = 0;
					snk_idle = 0;
					configure(1'b1, 8'hFF, 8'h00);
				end
			endcase
			phase_end = useful_cnt + target / 3;
			while (useful_cnt < phase_end) random_packet();
		end
	endtask

	initial begin : result_sink
		out_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (frame_q.size() == 0) begin
					$display("%0t: unexpected word byte=%h status=%0d last=%b",
						$time, out_byte, status, last);
					err_cnt++;
				end else begin
					want = frame_q.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
						err_cnt++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						err_cnt++;
					end
					if (last !== want.lst) begin
						$display("%0t: last expected %b actual %b", $time, want.lst, last);
						err_cnt++;
					end
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < snk_idle);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_link_not_ready();
		test_frame_shapes();
		test_length_limits();
		test_markers();
		test_backpressure();
		test_random(170);
		wait_drain();
		if (err_cnt == 0 && frame_q.size() == 0) begin
			$display("tb_packet_framer_xor_checksum: PASS");
		end else begin
			$display("tb_packet_framer_xor_checksum: FAIL");
		end
		$finish;
	end

endmodule
